// File: sv/pct_pkg.sv
// Shared constants, codes and memory write-port types for the pair coverage table.
`timescale 1ns / 1ps

package pct_pkg;

    localparam int VALUE_COUNT = 64;
    localparam int VAL_AW      = $clog2(VALUE_COUNT);
    localparam int CNT_W       = $clog2(VALUE_COUNT + 1);
    localparam int PAIR_DEPTH  = VALUE_COUNT * VALUE_COUNT;
    localparam int PAIR_AW     = $clog2(PAIR_DEPTH);

    localparam int FIELD_W = 6;
    localparam int KIND_W  = 2;
    localparam int PAIR_W  = 8;
    localparam int VAL_W   = 16;
    localparam int TOTAL_W = 20;
    localparam int COV_W   = 8;
    localparam int VIU_W   = 7;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    localparam logic REG_COVERAGE = 1'b0;
    localparam logic REG_VALUES   = 1'b1;

    typedef struct packed {
        logic               we;
        logic [PAIR_AW-1:0] addr;
        logic [PAIR_W-1:0]  data;
    } pair_wr_t;

    typedef struct packed {
        logic              we;
        logic [VAL_AW-1:0] addr;
        logic [VAL_W-1:0]  data;
    } val_wr_t;

endpackage

// File: sv/pct_pair_mem.sv
// Pair count memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pct_pair_mem
    import pct_pkg::*;
(
    input  logic               clk,
    input  pair_wr_t           wr,
    input  logic [PAIR_AW-1:0] raddr,
    output logic [PAIR_W-1:0]  rdata
);

    logic [PAIR_W-1:0] mem [PAIR_DEPTH];
    logic [PAIR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/pct_value_mem.sv
// Per-value count memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module pct_value_mem
    import pct_pkg::*;
(
    input  logic              clk,
    input  val_wr_t           wr,
    input  logic [VAL_AW-1:0] raddr0,
    input  logic [VAL_AW-1:0] raddr1,
    output logic [VAL_W-1:0]  rdata0,
    output logic [VAL_W-1:0]  rdata1
);

    logic [VAL_W-1:0] mem [VALUE_COUNT];
    logic [VAL_W-1:0] rdata0_reg;
    logic [VAL_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// File: sv/pair_coverage_table.sv
// Pair coverage table top level: sequencer, registers and stream/APB ports.
`timescale 1ns / 1ps
// Steps from accept to result word in the output register: a find, or a pair op that changes
// nothing, goes through EXEC; an insert or remove that updates counts goes through EXEC and
// WRB; a query goes through SCAN over the first n = min(values_in_use, 64) values. A new word
// is taken only in IDLE, after the last result has been handed off; the single value-memory
// write port needs WRB; the query scan reads one count per cycle. After rst_n deasserts, a clearing
// pass zeroes both memories and holds s_tready low. Configuration writes are taken at any time.

module pair_coverage_table
    import pct_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [5:0] first_value, [11:6] second_value
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] remaining, [8] hit,
                                             // [14:9] best_value, [34:15] total_remaining
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_WRB   = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_SEND  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [PAIR_AW-1:0] clr_reg, clr_next;

    // captured item
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [FIELD_W-1:0] a_reg, a_next;
    logic [FIELD_W-1:0] b_reg, b_next;
    logic [PAIR_AW-1:0] idx_reg, idx_next;
    logic               ok_reg, ok_next;
    logic [VAL_W-1:0]   vb_new_reg, vb_new_next;

    // query scan
    logic [VAL_AW-1:0]  scan_idx_reg, scan_idx_next;
    logic [VAL_W-1:0]   best_cnt_reg, best_cnt_next;
    logic [VAL_AW-1:0]  best_val_reg, best_val_next;

    // configuration and running total
    logic [COV_W-1:0]   cov_reg, cov_next;
    logic [VIU_W-1:0]   viu_reg, viu_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // finished result waiting for the output register
    logic [PAIR_W-1:0]  res_rem_reg, res_rem_next;
    logic               res_hit_reg, res_hit_next;
    logic [FIELD_W-1:0] res_best_reg, res_best_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [PAIR_W-1:0]  out_rem_reg, out_rem_next;
    logic               out_hit_reg, out_hit_next;
    logic [FIELD_W-1:0] out_best_reg, out_best_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;

    // memory ports
    pair_wr_t           pair_wr;
    val_wr_t            val_wr;
    logic [PAIR_W-1:0]  pair_rdata;
    logic [VAL_W-1:0]   val_rdata0;
    logic [VAL_W-1:0]   val_rdata1;
    logic [VAL_AW-1:0]  rd0_addr;

    // input decode
    logic [KIND_W-1:0]  in_kind;
    logic [FIELD_W-1:0] in_first;
    logic [FIELD_W-1:0] in_second;
    logic [FIELD_W-1:0] in_lo;
    logic [FIELD_W-1:0] in_hi;
    logic               in_ok;
    logic [PAIR_AW-1:0] in_idx;

    logic               accept;
    logic               fin;
    logic               load;
    logic               cfg_wr;
    logic [CNT_W-1:0]   scan_len;
    logic               scan_cmp;
    logic               scan_better;
    logic               scan_last;

    assign in_kind   = s_tuser;
    assign in_first  = s_tdata[FIELD_W-1:0];
    assign in_second = s_tdata[2*FIELD_W-1:FIELD_W];
    assign in_lo     = (in_first < in_second) ? in_first : in_second;
    assign in_hi     = (in_first < in_second) ? in_second : in_first;
    // Equal values never form a pair; values past the table are treated as absent.
    assign in_ok     = (in_lo != in_hi) && (CNT_W'(in_hi) < CNT_W'(VALUE_COUNT));
    assign in_idx    = PAIR_AW'(PAIR_AW'(in_lo) * PAIR_AW'(VALUE_COUNT) + PAIR_AW'(in_hi));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Scan length is clamped to the table size; a length of zero compares nothing.
    assign scan_len = (CNT_W'(viu_reg) > CNT_W'(VALUE_COUNT)) ? CNT_W'(VALUE_COUNT)
                                                              : CNT_W'(viu_reg);
    assign scan_cmp    = CNT_W'(scan_idx_reg) < scan_len;
    assign scan_better = scan_cmp && (val_rdata0 > best_cnt_reg);
    assign scan_last   = (scan_idx_reg == VAL_AW'(VALUE_COUNT - 1))
                      || ((CNT_W'(scan_idx_reg) + CNT_W'(1)) >= scan_len);

    pct_pair_mem u_pair_mem (
        .clk   (clk),
        .wr    (pair_wr),
        .raddr (in_idx),
        .rdata (pair_rdata)
    );

    pct_value_mem u_value_mem (
        .clk    (clk),
        .wr     (val_wr),
        .raddr0 (rd0_addr),
        .raddr1 (VAL_AW'(in_second)),
        .rdata0 (val_rdata0),
        .rdata1 (val_rdata1)
    );

    // APB: pready is tied high, so a write lands in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_COVERAGE: prdata = 32'(cov_reg);
            REG_VALUES:   prdata = 32'(viu_reg);
        endcase
    end

    always_comb
    begin
        cov_next = cov_reg;
        viu_next = viu_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_COVERAGE: cov_next = pwdata[COV_W-1:0];
                REG_VALUES:   viu_next = pwdata[VIU_W-1:0];
            endcase
        end
    end

    // Sequencer. An item is only taken in IDLE, after the previous item has written
    // back everything, so a read never overlaps a pending write to the same entry.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        kind_next     = kind_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        vb_new_next   = vb_new_reg;
        scan_idx_next = scan_idx_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        total_next    = total_reg;
        res_rem_next  = res_rem_reg;
        res_hit_next  = res_hit_reg;
        res_best_next = res_best_reg;
        pair_wr       = '0;
        val_wr        = '0;
        rd0_addr      = scan_idx_reg + VAL_AW'(1);
        fin           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one pair entry per cycle; the value memory wraps along.
                pair_wr.we   = 1'b1;
                pair_wr.addr = clr_reg;
                pair_wr.data = '0;
                val_wr.we    = 1'b1;
                val_wr.addr  = clr_reg[VAL_AW-1:0];
                val_wr.data  = '0;
                clr_next     = clr_reg + PAIR_AW'(1);
                if (clr_reg == PAIR_AW'(PAIR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // Reads go out on the accept edge; a query starts at value 0.
                rd0_addr = (in_kind == KIND_QUERY) ? '0 : VAL_AW'(in_first);
                if (accept)
                begin
                    kind_next = in_kind;
                    a_next    = in_first;
                    b_next    = in_second;
                    idx_next  = in_idx;
                    ok_next   = in_ok;
                    if (in_kind == KIND_QUERY)
                    begin
                        scan_idx_next = '0;
                        best_cnt_next = '0;
                        best_val_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                res_rem_next  = '0;
                res_hit_next  = 1'b0;
                res_best_next = '0;
                fin           = 1'b1;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (ok_reg && pair_rdata != '0)
                        begin
                            res_rem_next = pair_rdata;
                        end
                        else if (ok_reg && cov_reg != '0)
                        begin
                            pair_wr.we   = 1'b1;
                            pair_wr.addr = idx_reg;
                            pair_wr.data = cov_reg;
                            val_wr.we    = 1'b1;
                            val_wr.addr  = VAL_AW'(a_reg);
                            val_wr.data  = val_rdata0 + VAL_W'(cov_reg);
                            vb_new_next  = val_rdata1 + VAL_W'(cov_reg);
                            total_next   = total_reg + TOTAL_W'({cov_reg, 1'b0});
                            res_rem_next = cov_reg;
                            res_hit_next = 1'b1;
                            fin          = 1'b0;
                            state_next   = ST_WRB;
                        end
                    end
                    KIND_FIND:
                    begin
                        res_rem_next = ok_reg ? pair_rdata : '0;
                        res_hit_next = ok_reg && (pair_rdata != '0);
                    end
                    KIND_REMOVE:
                    begin
                        if (ok_reg && pair_rdata != '0)
                        begin
                            pair_wr.we   = 1'b1;
                            pair_wr.addr = idx_reg;
                            pair_wr.data = pair_rdata - PAIR_W'(1);
                            val_wr.we    = 1'b1;
                            val_wr.addr  = VAL_AW'(a_reg);
                            val_wr.data  = val_rdata0 - VAL_W'(1);
                            vb_new_next  = val_rdata1 - VAL_W'(1);
                            total_next   = total_reg - TOTAL_W'(2);
                            res_rem_next = pair_rdata - PAIR_W'(1);
                            res_hit_next = 1'b1;
                            fin          = 1'b0;
                            state_next   = ST_WRB;
                        end
                    end
                    KIND_QUERY:
                    begin
                        // queries go through the scan, never here
                    end
                endcase
            end

            ST_WRB:
            begin
                // Second value count goes through the single write port.
                val_wr.we   = 1'b1;
                val_wr.addr = VAL_AW'(b_reg);
                val_wr.data = vb_new_reg;
                fin         = 1'b1;
            end

            ST_SCAN:
            begin
                // One count arrives per cycle; strict compare keeps the lowest index on ties.
                if (scan_better)
                begin
                    best_cnt_next = val_rdata0;
                    best_val_next = scan_idx_reg;
                end
                if (scan_last)
                begin
                    res_rem_next  = '0;
                    res_hit_next  = 1'b0;
                    res_best_next = FIELD_W'(scan_better ? scan_idx_reg : best_val_reg);
                    fin           = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + VAL_AW'(1);
                end
            end

            ST_SEND:
            begin
                fin = 1'b1;
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // Hand the result to the output register when it is free or being drained;
        // otherwise park in SEND.
        load = fin && (!out_valid_reg || m_tready);
        if (fin)
        begin
            state_next = load ? ST_IDLE : ST_SEND;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rem_next   = out_rem_reg;
        out_hit_next   = out_hit_reg;
        out_best_next  = out_best_reg;
        out_total_next = out_total_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_rem_next   = res_rem_next;
            out_hit_next   = res_hit_next;
            out_best_next  = res_best_next;
            out_total_next = total_next;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cov_reg       <= COV_W'(1);
            viu_reg       <= VIU_W'(64);
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cov_reg       <= cov_next;
            viu_reg       <= viu_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        idx_reg       <= idx_next;
        ok_reg        <= ok_next;
        vb_new_reg    <= vb_new_next;
        scan_idx_reg  <= scan_idx_next;
        best_cnt_reg  <= best_cnt_next;
        best_val_reg  <= best_val_next;
        res_rem_reg   <= res_rem_next;
        res_hit_reg   <= res_hit_next;
        res_best_reg  <= res_best_next;
        out_rem_reg   <= out_rem_next;
        out_hit_reg   <= out_hit_next;
        out_best_reg  <= out_best_next;
        out_total_reg <= out_total_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_total_reg, out_best_reg, out_hit_reg, out_rem_reg};

    // A pair operation always moves to the execute step right after it is taken.
    a_pair_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind != KIND_QUERY) |=> (state_reg == ST_EXEC))
        else $error("pair operation did not enter execute step");

    // A pair write in the execute step is always followed by the second count write.
    a_exec_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && pair_wr.we) |=> (state_reg == ST_WRB))
        else $error("second value count write skipped");

    // The running total only moves on the execute step.
    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EXEC) |=> (total_reg == $past(total_reg)))
        else $error("total changed outside execute step");

    // No item is taken before the clearing pass ends.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("item accepted during clearing pass");

endmodule
